### src/bpfd_pkg.sv
// shared codes and control/status types for the packet buffer
`timescale 1ns / 1ps

package bpfd_pkg;

    // request kinds
    localparam logic [1:0] FUNC_ADD     = 2'd0;
    localparam logic [1:0] FUNC_FORWARD = 2'd1;
    localparam logic [1:0] FUNC_COUNT   = 2'd2;

    localparam int SRC_W   = 16;
    localparam int DST_W   = 16;
    localparam int TS_W    = 32;
    localparam int WORD_W  = SRC_W + DST_W + TS_W;
    localparam int LIMIT_W = 7;
    localparam int CNT_W   = 7;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;
    localparam logic [CNT_W-1:0]   CNT_MAX     = 7'd127;

    typedef logic [WORD_W-1:0] word_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;       // latch request fields, clear scan flags
        logic scan_init;  // start a scan at the head
        logic scan_step;  // issue one store read and advance
        logic commit;     // append the latched entry if not a duplicate
        logic read_head;  // read the oldest entry
        logic pop;        // drop the oldest entry
        logic out_load;   // move the result into the output register
    } cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic [1:0] func;
        logic       empty;
        logic       last;     // one scan read left to issue
        logic       out_busy; // output register holds a stalled result
    } status_t;

endpackage

### src/bpfd_ctrl.sv
// request sequencer for the packet buffer
`timescale 1ns / 1ps

module bpfd_ctrl
    import bpfd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    req_valid,
    output logic    req_stall,
    input  status_t status,
    output cmd_t    cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_START  = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_DRAIN  = 3'd3;
    localparam logic [2:0] S_COMMIT = 3'd4;
    localparam logic [2:0] S_FWD    = 3'd5;
    localparam logic [2:0] S_RESULT = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign req_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                case (status.func)
                    FUNC_ADD:
                    begin
                        if (status.empty)
                        begin
                            state_next = S_COMMIT;
                        end
                        else
                        begin
                            cmd.scan_init = 1'b1;
                            state_next    = S_SCAN;
                        end
                    end
                    FUNC_COUNT:
                    begin
                        if (status.empty)
                        begin
                            state_next = S_RESULT;
                        end
                        else
                        begin
                            cmd.scan_init = 1'b1;
                            state_next    = S_SCAN;
                        end
                    end
                    FUNC_FORWARD:
                    begin
                        if (status.empty)
                        begin
                            state_next = S_RESULT;
                        end
                        else
                        begin
                            cmd.read_head = 1'b1;
                            state_next    = S_FWD;
                        end
                    end
                    default:
                    begin
                        state_next = S_RESULT;
                    end
                endcase
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                // last compare lands here
                if (status.func == FUNC_ADD)
                begin
                    state_next = S_COMMIT;
                end
                else
                begin
                    state_next = S_RESULT;
                end
            end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = S_RESULT;
            end
            S_FWD:
            begin
                cmd.pop    = 1'b1;
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### src/bpfd_dp.sv
// packet store, pointers, scan compare and result register
`timescale 1ns / 1ps

module bpfd_dp
    import bpfd_pkg::*;
#(
    parameter int BUFFER_DEPTH = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cmd_t                 cmd,
    output status_t              status,
    input  logic                 cfg_write,
    input  logic [LIMIT_W-1:0]   cfg_limit,
    input  logic [1:0]           func,
    input  logic [SRC_W-1:0]     source,
    input  logic [DST_W-1:0]     destination,
    input  logic [TS_W-1:0]      timestamp,
    input  logic [TS_W-1:0]      start_time,
    input  logic [TS_W-1:0]      end_time,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output logic                 accepted,
    output logic                 has_packet,
    output logic [SRC_W-1:0]     out_source,
    output logic [DST_W-1:0]     out_destination,
    output logic [TS_W-1:0]      out_timestamp,
    output logic [CNT_W-1:0]     match_count
);

    localparam int PTR_W = $clog2(BUFFER_DEPTH);
    localparam int OCC_W = $clog2(BUFFER_DEPTH + 1);
    localparam int CMP_W = (OCC_W > LIMIT_W) ? OCC_W : LIMIT_W;
    localparam logic [PTR_W-1:0] LAST_SLOT  = PTR_W'(BUFFER_DEPTH - 1);
    localparam logic [CMP_W-1:0] DEPTH_CMP  = CMP_W'(BUFFER_DEPTH);

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        return (p == LAST_SLOT) ? '0 : p + 1'b1;
    endfunction

    word_t mem [BUFFER_DEPTH];

    logic [LIMIT_W-1:0] limit_reg;
    logic [PTR_W-1:0]   head_reg;
    logic [PTR_W-1:0]   tail_reg;
    logic [OCC_W-1:0]   occ_reg;
    logic [PTR_W-1:0]   scan_ptr_reg;
    logic [OCC_W-1:0]   remain_reg;
    logic               cmp_valid_reg;
    logic               dup_reg;
    logic               hit_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [1:0]         func_reg;
    word_t              word_reg;
    logic [TS_W-1:0]    start_reg;
    logic [TS_W-1:0]    end_reg;
    word_t              rd_data_reg;
    logic               out_valid_reg;

    logic               rd_en;
    logic [PTR_W-1:0]   rd_addr;
    logic               full;
    logic [LIMIT_W-1:0] lim_eff;
    logic               word_eq;
    logic               in_window;
    logic [DST_W-1:0]   rd_dst;
    logic [TS_W-1:0]    rd_ts;

    assign rd_en   = cmd.scan_step | cmd.read_head;
    assign rd_addr = cmd.read_head ? head_reg : scan_ptr_reg;

    // limit of zero acts as one, above depth acts as depth
    assign lim_eff = (limit_reg == '0) ? LIMIT_W'(1) : limit_reg;
    assign full    = (CMP_W'(occ_reg) >= DEPTH_CMP) || (CMP_W'(occ_reg) >= CMP_W'(lim_eff));

    assign rd_dst    = rd_data_reg[TS_W +: DST_W];
    assign rd_ts     = rd_data_reg[TS_W-1:0];
    assign word_eq   = (rd_data_reg == word_reg);
    assign in_window = (rd_dst == word_reg[TS_W +: DST_W]) &&
                       (rd_ts >= start_reg) && (rd_ts <= end_reg);

    assign status.func     = func_reg;
    assign status.empty    = (occ_reg == '0);
    assign status.last     = (remain_reg == OCC_W'(1));
    assign status.out_busy = out_valid_reg & rsp_stall;

    // packet store: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (cmd.commit && !dup_reg)
        begin
            mem[tail_reg] <= word_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // request fields
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            word_reg  <= {source, destination, timestamp};
            start_reg <= start_time;
            end_reg   <= end_time;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= LIMIT_RESET;
            head_reg      <= '0;
            tail_reg      <= '0;
            occ_reg       <= '0;
            scan_ptr_reg  <= '0;
            remain_reg    <= '0;
            cmp_valid_reg <= 1'b0;
            dup_reg       <= 1'b0;
            hit_reg       <= 1'b0;
            count_reg     <= '0;
            func_reg      <= FUNC_ADD;
        end
        else
        begin
            if (cfg_write)
            begin
                limit_reg <= cfg_limit;
            end
            cmp_valid_reg <= cmd.scan_step;
            if (cmd.load)
            begin
                func_reg  <= func;
                dup_reg   <= 1'b0;
                hit_reg   <= 1'b0;
                count_reg <= '0;
            end
            if (cmd.scan_init)
            begin
                scan_ptr_reg <= head_reg;
                remain_reg   <= occ_reg;
            end
            if (cmd.scan_step)
            begin
                scan_ptr_reg <= next_slot(scan_ptr_reg);
                remain_reg   <= remain_reg - 1'b1;
            end
            if (cmp_valid_reg)
            begin
                if (word_eq)
                begin
                    dup_reg <= 1'b1;
                end
                if (in_window && (count_reg != CNT_MAX))
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end
            if (cmd.read_head)
            begin
                hit_reg <= 1'b1;
            end
            if (cmd.commit && !dup_reg)
            begin
                tail_reg <= next_slot(tail_reg);
                if (full)
                begin
                    // evict oldest, occupancy unchanged
                    head_reg <= next_slot(head_reg);
                end
                else
                begin
                    occ_reg <= occ_reg + 1'b1;
                end
            end
            if (cmd.pop)
            begin
                head_reg <= next_slot(head_reg);
                occ_reg  <= occ_reg - 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            accepted    <= (func_reg == FUNC_ADD) && !dup_reg;
            has_packet  <= (func_reg == FUNC_FORWARD) && hit_reg;
            match_count <= (func_reg == FUNC_COUNT) ? count_reg : '0;
            if ((func_reg == FUNC_FORWARD) && hit_reg)
            begin
                out_source      <= rd_data_reg[TS_W + DST_W +: SRC_W];
                out_destination <= rd_data_reg[TS_W +: DST_W];
                out_timestamp   <= rd_data_reg[TS_W-1:0];
            end
            else
            begin
                out_source      <= '0;
                out_destination <= '0;
                out_timestamp   <= '0;
            end
        end
    end

    assign rsp_valid = out_valid_reg;

endmodule

### src/bounded_packet_fifo_with_dedup_count.sv
// top level of the bounded packet buffer with duplicate filter and window count
`timescale 1ns / 1ps

// bounded packet buffer: holds up to memory_limit (source, destination,
// timestamp) entries, at least one and at most BUFFER_DEPTH, in arrival
// order in a single-port-read store of BUFFER_DEPTH entries. func 0 adds an
// entry unless an identical one is held, evicting the oldest when full;
// func 1 pops and returns the oldest; func 2 counts held entries with a
// given destination and timestamp in [start_time, end_time], saturating at
// 127; func 3 returns all zeros. one request is worked at a time. the add
// and count requests scan the held entries one store read per cycle. the
// sequencer returns to idle after each load of the result register and
// takes the next request there. the result sits in an output register, so a
// new request is taken while an earlier result still waits on rsp_stall.
// memory_limit may only be written while no request is in flight; the store
// needs no clearing after reset.

module bounded_packet_fifo_with_dedup_count
    import bpfd_pkg::*;
#(
    parameter int BUFFER_DEPTH = 64
)
(
    input  logic                clk,
    input  logic                rst_n,

    // request channel
    input  logic                req_valid,
    output logic                req_stall,
    input  logic [1:0]          func,
    input  logic [SRC_W-1:0]    source,
    input  logic [DST_W-1:0]    destination,
    input  logic [TS_W-1:0]     timestamp,
    input  logic [TS_W-1:0]     start_time,
    input  logic [TS_W-1:0]     end_time,

    // result channel
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output logic                accepted,
    output logic                has_packet,
    output logic [SRC_W-1:0]    out_source,
    output logic [DST_W-1:0]    out_destination,
    output logic [TS_W-1:0]     out_timestamp,
    output logic [CNT_W-1:0]    match_count,

    // configuration write channel
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [LIMIT_W-1:0]  memory_limit
);

    cmd_t    cmd;
    status_t status;

    // the limit register is always writable
    assign cfg_ready = 1'b1;

    // sequencer: walks each request through scan, commit or pop
    bpfd_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // store, pointers, compare logic and output register
    bpfd_dp #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_dp
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .cfg_write       (cfg_valid & cfg_ready),
        .cfg_limit       (memory_limit),
        .func            (func),
        .source          (source),
        .destination     (destination),
        .timestamp       (timestamp),
        .start_time      (start_time),
        .end_time        (end_time),
        .rsp_valid       (rsp_valid),
        .rsp_stall       (rsp_stall),
        .accepted        (accepted),
        .has_packet      (has_packet),
        .out_source      (out_source),
        .out_destination (out_destination),
        .out_timestamp   (out_timestamp),
        .match_count     (match_count)
    );

endmodule
